// ----- rtl/sdssf_pkg.sv -----
// Package: microcode types, step addresses, display codes and the control store.
`timescale 1ns / 1ps

package sdssf_pkg;

    localparam int unsigned CODE_DASH  = 10;
    localparam int unsigned CODE_BLANK = 15;
    localparam logic [7:0]  DOT_BIT    = 8'h80;

    // Reciprocal of ten, scaled by 2^35; exact floor(x / 10) for every 32-bit x.
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_DIGIT_COUNT   = 3'd0,
        REG_DIGIT_OFFSET  = 3'd1,
        REG_DP_POSITION   = 3'd2,
        REG_USE_TABLE     = 3'd3,
        REG_TABLE_LOW     = 3'd4,
        REG_TABLE_HIGH    = 3'd5
    } t_reg_index;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_ZCHK  = 3'd1;
    localparam t_step STEP_DIV   = 3'd2;
    localparam t_step STEP_EMIT  = 3'd3;
    localparam t_step STEP_NEG   = 3'd4;
    localparam t_step STEP_DASH  = 3'd5;

    typedef enum logic [2:0] {
        UOP_WAIT_IN,
        UOP_NOP,
        UOP_DIV,
        UOP_EMIT_DIGIT,
        UOP_EMIT_DASH
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_COUNT_ZERO,
        COND_MORE_DIGITS,
        COND_POSITIVE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Control store: one word per step; jump to target when cond holds.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_IDLE: w = '{op: UOP_WAIT_IN,    cond: COND_NEVER,       target: STEP_IDLE};
            STEP_ZCHK: w = '{op: UOP_NOP,        cond: COND_COUNT_ZERO,  target: STEP_IDLE};
            STEP_DIV:  w = '{op: UOP_DIV,        cond: COND_NEVER,       target: STEP_IDLE};
            STEP_EMIT: w = '{op: UOP_EMIT_DIGIT, cond: COND_MORE_DIGITS, target: STEP_DIV};
            STEP_NEG:  w = '{op: UOP_NOP,        cond: COND_POSITIVE,    target: STEP_IDLE};
            STEP_DASH: w = '{op: UOP_EMIT_DASH,  cond: COND_ALWAYS,      target: STEP_IDLE};
            default:   w = '{op: UOP_NOP,        cond: COND_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Code-B or table pattern, with optional dot.
    function automatic logic [7:0] encode(input logic [3:0] code, input logic dot,
                                          input logic use_table,
                                          input logic [127:0] table_bits);
        logic [7:0] b;
        b = use_table ? table_bits[{code, 3'b000} +: 8] : {4'b0000, code};
        return dot ? (b | DOT_BIT) : b;
    endfunction

endpackage

// ----- rtl/signed_decimal_seven_segment_formatter.sv -----
// Top level: signed binary to decimal digit-code formatter for seven-segment displays.
`timescale 1ns / 1ps

// Takes one signed 32-bit value per item and emits one digit write per display
// position, least significant digit first, at positions digit_offset + j for
// j = 0 .. digit_count-1 (digit_count saturates at MAX_DIGITS, 4-bit position
// wraps). A negative value adds one more write: a dash over the highest
// position. A digit count of zero produces nothing. Output tdata: [3:0]
// position, [11:4] segment code (Code-B or table pattern, dot is bit 7).
// The sequencer holds an emit step while the output sink stalls. Each
// digit costs two microcode steps, a reciprocal multiply by 1/10 and then the
// remainder subtract and emit. One item is in flight at a time; s_axis_tready
// is high only while the sequencer waits at its idle step. Configuration
// writes are always accepted and must be made while the block is idle.
module signed_decimal_seven_segment_formatter #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream; tdata: [31:0] value
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // output stream; tdata: [3:0] digit_position, [11:4] segment_code, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sdssf_pkg::*;

    localparam int JW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // configuration registers
    logic [3:0]   r_digit_count;
    logic [2:0]   r_digit_offset;
    logic [3:0]   r_dp;
    logic         r_use_table;
    logic [63:0]  r_table_low;
    logic [63:0]  r_table_high;

    // datapath
    t_step        r_step, n_step;
    logic [31:0]  r_mag;
    logic [28:0]  r_quo;
    logic         r_neg;
    logic [4:0]   r_n;
    logic [JW-1:0] r_j;

    // output register
    logic         r_out_valid;
    logic [3:0]   r_out_pos;
    logic [7:0]   r_out_code;
    logic         r_out_last;

    t_uword       uw;
    logic         in_fire;
    logic         out_free;
    logic         hold;
    logic         cond_true;
    logic         emit;
    logic [4:0]   j5;
    logic [4:0]   dp5;
    logic         dp_valid;
    logic         at_last_digit;
    logic [63:0]  product;
    logic [31:0]  rem_full;
    logic [3:0]   digit_code;
    logic         digit_dot;
    logic [4:0]   n_sat;
    logic [4:0]   dash_pos;
    logic [7:0]   emit_code;
    logic [3:0]   emit_pos;
    logic         emit_last;

    assign uw            = ucode_rom(r_step);
    assign s_axis_tready = (r_step == STEP_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // digit math: quotient comes from the registered multiply step
    assign product   = r_mag * RECIP_TEN;
    assign rem_full  = r_mag - ({r_quo, 3'b000} + {2'b00, r_quo, 1'b0});

    assign j5       = 5'(r_j);
    assign dp_valid = !r_dp[3];
    assign dp5      = {2'b00, r_dp[2:0]};
    assign at_last_digit = (j5 == r_n - 5'd1);

    // zero fill up to the dot, blank beyond; lone 0 when there is no dot
    always_comb begin
        if (r_mag != 32'd0) begin
            digit_code = rem_full[3:0];
        end else if (j5 == 5'd0 && !dp_valid) begin
            digit_code = 4'd0;
        end else if (dp_valid && j5 <= dp5) begin
            digit_code = 4'd0;
        end else begin
            digit_code = 4'(CODE_BLANK);
        end
    end
    assign digit_dot = dp_valid && (j5 == dp5);

    assign n_sat    = ({1'b0, r_digit_count} > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS)
                                                                : {1'b0, r_digit_count};
    assign dash_pos = {2'b00, r_digit_offset} + r_n - 5'd1;

    always_comb begin
        emit = 1'b0;
        emit_code = 8'd0;
        emit_pos  = 4'd0;
        emit_last = 1'b0;
        unique case (uw.op)
            UOP_EMIT_DIGIT: begin
                emit      = 1'b1;
                emit_code = encode(digit_code, digit_dot, r_use_table,
                                   {r_table_high, r_table_low});
                emit_pos  = 4'({1'b0, r_digit_offset}) + 4'(r_j);
                emit_last = at_last_digit && !r_neg;
            end
            UOP_EMIT_DASH: begin
                emit      = 1'b1;
                emit_code = encode(4'(CODE_DASH), 1'b0, r_use_table,
                                   {r_table_high, r_table_low});
                emit_pos  = dash_pos[3:0];
                emit_last = 1'b1;
            end
            UOP_WAIT_IN, UOP_NOP, UOP_DIV: begin
            end
            default: begin
            end
        endcase
    end

    // a step holds while it waits for an input item or for output space
    assign hold = ((uw.op == UOP_WAIT_IN) && !in_fire) || (emit && !out_free);

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_COUNT_ZERO:  cond_true = (r_n == 5'd0);
            COND_MORE_DIGITS: cond_true = !at_last_digit;
            COND_POSITIVE:    cond_true = !r_neg;
            default:          cond_true = 1'b1;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= STEP_IDLE;
            r_out_valid    <= 1'b0;
            r_digit_count  <= 4'd8;
            r_digit_offset <= 3'd0;
            r_dp           <= 4'hF;
            r_use_table    <= 1'b0;
            r_table_low    <= 64'd0;
            r_table_high   <= 64'd0;
        end else begin
            r_step <= n_step;
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_DIGIT_COUNT:  r_digit_count  <= i_cfg_data[3:0];
                    REG_DIGIT_OFFSET: r_digit_offset <= i_cfg_data[2:0];
                    REG_DP_POSITION:  r_dp           <= i_cfg_data[3:0];
                    REG_USE_TABLE:    r_use_table    <= i_cfg_data[0];
                    REG_TABLE_LOW:    r_table_low    <= i_cfg_data;
                    REG_TABLE_HIGH:   r_table_high   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_neg <= s_axis_tdata[31];
            r_mag <= s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;
            r_n   <= n_sat;
            r_j   <= '0;
        end
        if (uw.op == UOP_DIV) begin
            r_quo <= product[63:RECIP_SHIFT];
        end
        if (uw.op == UOP_EMIT_DIGIT && out_free) begin
            r_mag <= {3'b000, r_quo};
            r_j   <= r_j + JW'(1);
        end
        if (emit && out_free) begin
            r_out_pos  <= emit_pos;
            r_out_code <= emit_code;
            r_out_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_code, r_out_pos};
    assign m_axis_tlast  = r_out_last;

endmodule
